// ===== hdl/a256ctr_pkg.sv =====
// ----------------------------------------------------------------------------
// a256ctr_pkg
// Types, constants and round functions shared by the AES-256 CTR engine.
// ----------------------------------------------------------------------------
package a256ctr_pkg;

  // register indexes
  localparam logic [2:0] REG_KEY0  = 3'd0;
  localparam logic [2:0] REG_KEY1  = 3'd1;
  localparam logic [2:0] REG_KEY2  = 3'd2;
  localparam logic [2:0] REG_KEY3  = 3'd3;
  localparam logic [2:0] REG_NONCE = 3'd4;

  localparam int unsigned NUM_ROUNDS = 14;

  typedef struct packed {
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  byte_count;
    logic        message_start;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_high;
    logic [63:0] out_low;
    logic [4:0]  out_count;
  } out_item_t;

  // request handed from front to back: counter block, data, byte mask
  typedef struct packed {
    logic [127:0] ctr_blk;
    logic [127:0] data;
    logic [15:0]  mask;   // bit 15 is byte 0
    logic [4:0]   count;
  } job_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [7] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40};

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Next four schedule words from an eight-word window (oldest word on top).
  function automatic logic [127:0] next_words(input logic [255:0] win,
                                              input logic [7:0]   rc,
                                              input logic         rot);
    logic [31:0] t;
    logic [31:0] n0, n1, n2, n3;
    t  = rot ? (sub_word({win[23:0], win[31:24]}) ^ {rc, 24'h0}) : sub_word(win[31:0]);
    n0 = win[255:224] ^ t;
    n1 = win[223:192] ^ n0;
    n2 = win[191:160] ^ n1;
    n3 = win[159:128] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  // SubBytes, ShiftRows, MixColumns (skipped in the last round), AddRoundKey
  function automatic logic [127:0] aes_round(input logic [127:0] s,
                                             input logic [127:0] rk,
                                             input logic         last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) t[c*4+i] = SBOX[b[((c+i) & 3)*4+i]];
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[c*4];
      a1 = t[c*4+1];
      a2 = t[c*4+2];
      a3 = t[c*4+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      m[c*4]   = a0 ^ al ^ xtime(a0 ^ a1);
      m[c*4+1] = a1 ^ al ^ xtime(a1 ^ a2);
      m[c*4+2] = a2 ^ al ^ xtime(a2 ^ a3);
      m[c*4+3] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = (last ? t[i] : m[i]) ^ rk[127-8*i -: 8];
    end
    return r;
  endfunction

endpackage

// ===== hdl/aes256_ctr_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// aes256_ctr_stream_cipher
// AES-256 counter-mode engine with queue-style ports on both sides.
// ----------------------------------------------------------------------------
// Takes one 16-byte block per clock and delivers one result per clock in
// steady state, while pop keeps up. A pushed block passes through the front
// queue, the key-add stage, fourteen round stages and the output queue; the
// round stages form a fully unrolled pipeline, which expands the key
// schedule alongside the data. Up to OUT_DEPTH results may be in flight or
// waiting; when pop is held low that long, the pipeline stops issuing and full
// rises. Key and nonce registers may only be written while the engine holds
// no blocks.
module aes256_ctr_stream_cipher #(
  parameter int unsigned OUT_DEPTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  a256ctr_pkg::in_item_t  in_item_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   empty_o,
  output a256ctr_pkg::out_item_t out_item_o,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [63:0]            cfg_data_i
);

  logic [63:0] key0_q, key1_q, key2_q, key3_q, nonce_q;

  logic                   fq_push, fq_full, fq_empty, job_pop;
  a256ctr_pkg::job_t      job_in, job_out;
  logic                   core_valid;
  a256ctr_pkg::out_item_t core_item;
  logic                   out_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q  <= '0;
      key1_q  <= '0;
      key2_q  <= '0;
      key3_q  <= '0;
      nonce_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        a256ctr_pkg::REG_KEY0:  key0_q  <= cfg_data_i;
        a256ctr_pkg::REG_KEY1:  key1_q  <= cfg_data_i;
        a256ctr_pkg::REG_KEY2:  key2_q  <= cfg_data_i;
        a256ctr_pkg::REG_KEY3:  key3_q  <= cfg_data_i;
        a256ctr_pkg::REG_NONCE: nonce_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  a256ctr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .in_item_i (in_item_i),
    .nonce_i   (nonce_q),
    .q_full_i  (fq_full),
    .q_push_o  (fq_push),
    .job_o     (job_in)
  );

  assign full_o = fq_full;

  a256ctr_fifo #(
    .WIDTH ($bits(a256ctr_pkg::job_t)),
    .DEPTH (2)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .data_i  (job_in),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .full_o  (fq_full),
    .empty_o (fq_empty)
  );

  a256ctr_core #(
    .DEPTH (OUT_DEPTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_avail_i (!fq_empty),
    .job_i       (job_out),
    .key_i       ({key0_q, key1_q, key2_q, key3_q}),
    .out_pop_i   (pop_i && !empty_o),
    .job_pop_o   (job_pop),
    .out_valid_o (core_valid),
    .out_item_o  (core_item)
  );

  // credit in the core guarantees room here
  a256ctr_fifo #(
    .WIDTH ($bits(a256ctr_pkg::out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (core_valid),
    .data_i  (core_item),
    .pop_i   (pop_i),
    .data_o  (out_item_o),
    .full_o  (out_full),
    .empty_o (empty_o)
  );

endmodule

// ===== hdl/a256ctr_fifo.sv =====
// ----------------------------------------------------------------------------
// a256ctr_fifo
// Small register-based FIFO, first-word fall-through.
// ----------------------------------------------------------------------------
module a256ctr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/a256ctr_front.sv =====
// ----------------------------------------------------------------------------
// a256ctr_front
// Accepts data blocks, tracks the block counter, builds the counter block
// and byte mask for each request.
// ----------------------------------------------------------------------------
module a256ctr_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  a256ctr_pkg::in_item_t in_item_i,
  input  logic [63:0]           nonce_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output a256ctr_pkg::job_t     job_o
);

  logic        accept;
  logic [63:0] ctr_q, ctr_d, ctr_use;
  logic [4:0]  lim;

  assign accept   = push_i && !q_full_i;
  assign q_push_o = accept;
  assign ctr_use  = in_item_i.message_start ? 64'd0 : ctr_q;
  assign ctr_d    = ctr_use + 64'd1;
  // counts above sixteen saturate
  assign lim      = (in_item_i.byte_count > 5'd16) ? 5'd16 : in_item_i.byte_count;

  always_comb begin
    job_o.ctr_blk[127:64] = nonce_i;
    for (int i = 0; i < 8; i++) begin
      job_o.ctr_blk[63-8*i -: 8] = ctr_use[8*i +: 8];
    end
    job_o.data = {in_item_i.data_high, in_item_i.data_low};
    for (int i = 0; i < 16; i++) begin
      job_o.mask[15-i] = (5'(i) < lim);
    end
    job_o.count = in_item_i.byte_count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0;
    end else if (accept) begin
      ctr_q <= ctr_d;
    end
  end

endmodule

// ===== hdl/a256ctr_core.sv =====
// ----------------------------------------------------------------------------
// a256ctr_core
// Fully unrolled AES-256 pipeline with on-the-fly key schedule, one stage per
// round, and credit tracking against the output queue.
// ----------------------------------------------------------------------------
module a256ctr_core #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_avail_i,
  input  a256ctr_pkg::job_t      job_i,
  input  logic [255:0]           key_i,
  input  logic                   out_pop_i,
  output logic                   job_pop_o,
  output logic                   out_valid_o,
  output a256ctr_pkg::out_item_t out_item_o
);

  localparam int unsigned NR = a256ctr_pkg::NUM_ROUNDS;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]  cred_q, cred_d;
  logic           issue;

  logic           vld_q  [NR+1];
  logic [127:0]   st_q   [NR+1];
  logic [255:0]   win_q  [NR];
  logic [127:0]   dat_q  [NR+1];
  logic [15:0]    msk_q  [NR+1];
  logic [4:0]     cnt_q  [NR+1];

  logic [127:0]   ks, bytemask, res;

  // entries in flight or waiting in the output queue
  assign issue     = job_avail_i && (cred_q < CW'(DEPTH));
  assign job_pop_o = issue;

  always_comb begin
    cred_d = cred_q;
    if (issue && !out_pop_i) begin
      cred_d = cred_q + 1'b1;
    end else if (out_pop_i && !issue) begin
      cred_d = cred_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cred_q <= '0;
      vld_q[0] <= 1'b0;
    end else begin
      cred_q <= cred_d;
      vld_q[0] <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0]  <= job_i.ctr_blk ^ key_i[255:128];
    win_q[0] <= key_i;
    dat_q[0] <= job_i.data;
    msk_q[0] <= job_i.mask;
    cnt_q[0] <= job_i.count;
  end

  for (genvar r = 1; r <= NR; r++) begin : g_round
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[r] <= 1'b0;
      end else begin
        vld_q[r] <= vld_q[r-1];
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[r]  <= a256ctr_pkg::aes_round(st_q[r-1], win_q[r-1][127:0], (r == NR));
      dat_q[r] <= dat_q[r-1];
      msk_q[r] <= msk_q[r-1];
      cnt_q[r] <= cnt_q[r-1];
    end

    if (r < NR) begin : g_key
      always_ff @(posedge clk_i) begin
        win_q[r] <= {win_q[r-1][127:0],
                     a256ctr_pkg::next_words(win_q[r-1], a256ctr_pkg::RCON[(r-1)/2],
                                             (r % 2) == 1)};
      end
    end
  end

  assign ks = st_q[NR];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      bytemask[127-8*i -: 8] = {8{msk_q[NR][15-i]}};
    end
  end

  assign res                  = dat_q[NR] ^ (ks & bytemask);
  assign out_valid_o          = vld_q[NR];
  assign out_item_o.out_high  = res[127:64];
  assign out_item_o.out_low   = res[63:0];
  assign out_item_o.out_count = cnt_q[NR];

endmodule

// ===== hdl/a256ctr_checker.sv =====
// ----------------------------------------------------------------------------
// a256ctr_checker
// Port-level checks on the AES-256 CTR engine.
// ----------------------------------------------------------------------------
module a256ctr_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   push_i,
  input logic                   full_o,
  input logic                   pop_i,
  input logic                   empty_o,
  input a256ctr_pkg::out_item_t out_item_o
);

  logic [7:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = push_i && !full_o;
  assign out_acc = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 8'd1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 8'd1;
    end
  end

  a_no_result_without_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 8'd0 |-> empty_o)
    else $error("result shown with no request outstanding");

  a_full_needs_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> pend_q != 8'd0)
    else $error("full with nothing outstanding");

  a_no_immediate_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 8'd0 |=> empty_o)
    else $error("result appeared one cycle after request");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(out_item_o))
    else $error("waiting result changed or vanished");

endmodule

bind aes256_ctr_stream_cipher a256ctr_checker u_a256ctr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push_i     (push_i),
  .full_o     (full_o),
  .pop_i      (pop_i),
  .empty_o    (empty_o),
  .out_item_o (out_item_o)
);

// ===== dv/aes256_ctr_stream_cipher_tb.sv =====
// ----------------------------------------------------------------------------
// aes256_ctr_stream_cipher_tb
// Self-checking bench for the AES-256 CTR engine. A short table of blocks
// (the known zero-key vector, zero and oversize counts, message restarts)
// is followed by random messages under several key/nonce settings. Each
// result is checked against the value given in its table row or else a
// behavioral AES-256 CTR predictor. Both sides idle at random, and the pop
// side stalls once for a long stretch so that the engine fills up.
// ----------------------------------------------------------------------------
module aes256_ctr_stream_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_IDX [5] = '{a256ctr_pkg::REG_KEY0, a256ctr_pkg::REG_KEY1,
                                         a256ctr_pkg::REG_KEY2, a256ctr_pkg::REG_KEY3,
                                         a256ctr_pkg::REG_NONCE};
  localparam int NUM_RANDOM = 1530;

  typedef struct packed {
    a256ctr_pkg::in_item_t  blk;
    logic                   typed;   // expected result given in the row
    a256ctr_pkg::out_item_t res;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [14] = '{
    '{'{64'h0, 64'h0, 5'd16, 1'b1}, 1'b1, '{64'hdc95c078a2408989, 64'had48a21492842087, 5'd16}},
    '{'{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd0, 1'b0}, 1'b1,
      '{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd0}},
    '{'{64'h0, 64'h0, 5'd0, 1'b0}, 1'b1, '{64'h0, 64'h0, 5'd0}},
    '{'{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd16, 1'b0}, 1'b0, '0},
    '{'{64'hffffffffffffffff, 64'hffffffffffffffff, 5'd31, 1'b0}, 1'b0, '0},
    '{'{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd17, 1'b0}, 1'b0, '0},
    '{'{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 5'd1, 1'b0}, 1'b0, '0},
    '{'{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 5'd15, 1'b0}, 1'b0, '0},
    '{'{64'h0, 64'h0, 5'd16, 1'b1}, 1'b1, '{64'hdc95c078a2408989, 64'had48a21492842087, 5'd16}},
    '{'{64'h0, 64'hffffffffffffffff, 5'd8, 1'b0}, 1'b0, '0},
    '{'{64'hffffffffffffffff, 64'h0, 5'd9, 1'b0}, 1'b0, '0},
    '{'{64'h8000000000000001, 64'h8000000000000001, 5'd7, 1'b1}, 1'b0, '0},
    '{'{64'h0, 64'h0, 5'd24, 1'b0}, 1'b0, '0},
    '{'{64'h0f0f0f0f0f0f0f0f, 64'hf0f0f0f0f0f0f0f0, 5'd2, 1'b0}, 1'b0, '0}
  };

  logic                   clk_i, rst_ni;
  logic                   push_i, full_o, pop_i, empty_o;
  a256ctr_pkg::in_item_t  in_item_i;
  a256ctr_pkg::out_item_t out_item_o;
  logic                   cfg_we_i;
  logic [2:0]             cfg_idx_i;
  logic [63:0]            cfg_data_i;

  aes256_ctr_stream_cipher u_dut (.*);

  // predictor state
  logic [7:0]             sub_tab [256];
  logic [7:0]             rkey [240];
  logic [63:0]            key_nonce [5];
  logic [63:0]            blk_ctr;
  a256ctr_pkg::out_item_t exp_results [$];
  int                     n_errors;
  int                     n_popped;

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = xt(a);
    end
    return p;
  endfunction

  // S-box from the field inverse and the affine map
  task automatic build_sbox();
    logic [7:0] inv, b;
    for (int x = 0; x < 256; x++) begin
      inv = 8'd1;
      for (int k = 0; k < 254; k++) inv = gmul(inv, x[7:0]);
      if (x == 0) inv = '0;
      b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sub_tab[x] = b;
    end
  endtask

  task automatic expand_key();
    logic [7:0] t [4];
    logic [7:0] x, rc;
    rc = 8'h01;
    for (int w = 0; w < 4; w++)
      for (int i = 0; i < 8; i++) rkey[w*8+i] = key_nonce[w][63-8*i -: 8];
    for (int w = 8; w < 60; w++) begin
      for (int i = 0; i < 4; i++) t[i] = rkey[(w-1)*4+i];
      if ((w & 7) == 0) begin
        x = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = x;
        for (int i = 0; i < 4; i++) t[i] = sub_tab[t[i]];
        t[0] ^= rc;
        rc = xt(rc);
      end else if ((w & 7) == 4) begin
        for (int i = 0; i < 4; i++) t[i] = sub_tab[t[i]];
      end
      for (int i = 0; i < 4; i++) rkey[w*4+i] = rkey[(w-8)*4+i] ^ t[i];
    end
  endtask

  function automatic a256ctr_pkg::out_item_t ctr_encrypt(input a256ctr_pkg::in_item_t blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] d;
    int lim;
    a256ctr_pkg::out_item_t r;
    if (blk.message_start) blk_ctr = '0;
    for (int i = 0; i < 8; i++) begin
      s[i]   = key_nonce[4][63-8*i -: 8];
      s[8+i] = blk_ctr[8*i +: 8];
    end
    for (int i = 0; i < 16; i++) s[i] ^= rkey[i];
    for (int rnd = 1; rnd <= a256ctr_pkg::NUM_ROUNDS; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[c*4+i] = sub_tab[s[((c+i) & 3)*4+i]];
      for (int c = 0; c < 4; c++) begin
        a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        if (rnd < a256ctr_pkg::NUM_ROUNDS) begin
          s[c*4]   = a0 ^ al ^ xt(a0 ^ a1);
          s[c*4+1] = a1 ^ al ^ xt(a1 ^ a2);
          s[c*4+2] = a2 ^ al ^ xt(a2 ^ a3);
          s[c*4+3] = a3 ^ al ^ xt(a3 ^ a0);
        end else begin
          for (int i = 0; i < 4; i++) s[c*4+i] = t[c*4+i];
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= rkey[rnd*16+i];
    end
    d = {blk.data_high, blk.data_low};
    lim = (blk.byte_count > 16) ? 16 : blk.byte_count;
    for (int i = 0; i < lim; i++) d[127-8*i -: 8] ^= s[i];
    r.out_high  = d[127:64];
    r.out_low   = d[63:0];
    r.out_count = blk.byte_count;
    blk_ctr++;
    return r;
  endfunction

  // hand one block to the engine; returns once it is taken
  task automatic send_block(input a256ctr_pkg::in_item_t blk, input logic typed,
                            input a256ctr_pkg::out_item_t res);
    int gap;
    a256ctr_pkg::out_item_t pred;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i    <= 1'b1;
    in_item_i <= blk;
    do @(posedge clk_i); while (full_o);
    pred = ctr_encrypt(blk);
    exp_results.push_back(typed ? res : pred);
  endtask

  task automatic wait_drained();
    push_i <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [63:0] vals [5]);
    cfg_we_i <= 1'b1;
    for (int i = 0; i < 5; i++) begin
      cfg_idx_i  <= REG_IDX[i];
      cfg_data_i <= vals[i];
      key_nonce[i] = vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    expand_key();
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic a256ctr_pkg::in_item_t rand_block();
    a256ctr_pkg::in_item_t b;
    int sel;
    b.data_high = rand64();
    b.data_low  = rand64();
    sel = $urandom_range(0, 19);
    if (sel < 12)      b.byte_count = 5'd16;
    else if (sel < 17) b.byte_count = 5'($urandom_range(1, 15));
    else if (sel < 18) b.byte_count = 5'd0;
    else               b.byte_count = 5'($urandom_range(17, 31));
    b.message_start = ($urandom_range(0, 9) == 0);
    return b;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  // result side: random pops, one long hold-off to back the engine up
  initial begin
    int gap;
    pop_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 7);
      if (n_popped % 200 > 150) gap = 0;
      if (n_popped == 700) gap = 300;
      if (gap > 0) begin
        pop_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop_i <= 1'b1;
      do @(posedge clk_i); while (empty_o);
      n_popped++;
      if (exp_results.size() == 0) begin
        $display("%t unexpected result: actual %h", $realtime, out_item_o);
        n_errors++;
      end else begin
        a256ctr_pkg::out_item_t e;
        e = exp_results.pop_front();
        if (out_item_o.out_high !== e.out_high) begin
          $display("%t out_high: expected %h actual %h", $realtime, e.out_high,
                   out_item_o.out_high);
          n_errors++;
        end
        if (out_item_o.out_low !== e.out_low) begin
          $display("%t out_low: expected %h actual %h", $realtime, e.out_low,
                   out_item_o.out_low);
          n_errors++;
        end
        if (out_item_o.out_count !== e.out_count) begin
          $display("%t out_count: expected %0d actual %0d", $realtime, e.out_count,
                   out_item_o.out_count);
          n_errors++;
        end
      end
    end
  end

  initial begin
    logic [63:0] vals [5];
    n_errors   = 0;
    n_popped   = 0;
    rst_ni     = 1'b0;
    push_i     = 1'b0;
    in_item_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = a256ctr_pkg::REG_KEY0;
    cfg_data_i = '0;
    blk_ctr    = '0;
    for (int i = 0; i < 5; i++) key_nonce[i] = '0;
    build_sbox();
    expand_key();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: all-zero key and nonce
    foreach (DIR_TAB[i]) send_block(DIR_TAB[i].blk, DIR_TAB[i].typed, DIR_TAB[i].res);

    for (int phase = 0; phase < 5; phase++) begin
      wait_drained();
      for (int i = 0; i < 5; i++) begin
        case (phase)
          0:       vals[i] = '1;
          1:       vals[i] = rand64();
          2:       vals[i] = (i == 4) ? 64'hffffffffffffffff : 64'h0;
          3:       vals[i] = 64'h0;
          default: vals[i] = rand64();
        endcase
      end
      write_regs(vals);
      for (int n = 0; n < NUM_RANDOM / 5; n++) send_block(rand_block(), 1'b0, '0);
    end

    push_i <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
